/* rtl/number_to_display_text_unit_defines.svh */
// Assertion macros shared by the number-to-display-text RTL.
`ifndef NUMBER_TO_DISPLAY_TEXT_UNIT_DEFINES_SVH
`define NUMBER_TO_DISPLAY_TEXT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Condition implies consequence in the same cycle.
`define NTD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ntd same-cycle check failed");
// Condition implies consequence in the next cycle.
`define NTD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ntd next-cycle check failed");
`else
`define NTD_ASSERT_IMP(label, clk, rst, ante, cons)
`define NTD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/ntd_pkg.sv */
// Types and constants for the number-to-display-text unit.
`timescale 1ns / 1ps
package ntd_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CODE_WIDTH  = 8;
   localparam int BCD_DIGITS  = 10;
   localparam int BCD_WIDTH   = 4 * BCD_DIGITS;
   localparam int BYTE_BITS   = 8;

   // Format selector codes.
   localparam logic FUNC_DECIMAL = 1'b0;
   localparam logic FUNC_BINARY  = 1'b1;

   // Character and command codes.
   localparam logic [CODE_WIDTH-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CODE_WIDTH-1:0] ASCII_NINE  = 8'h39;
   localparam logic [CODE_WIDTH-1:0] ASCII_MINUS = 8'h2D;
   localparam logic [CODE_WIDTH-1:0] CMD_CLEAR   = 8'h01;

   typedef logic [CODE_WIDTH-1:0] code_type;

   // One classified word waiting for conversion.
   typedef struct packed {
      logic                   func;
      logic                   neg;
      logic [VALUE_WIDTH-1:0] mag;
   } job_type;

endpackage

/* rtl/ntd_front.sv */
// Front end: accepts request words, classifies them and hands them to the queue.
`timescale 1ns / 1ps
module ntd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic signed [ntd_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                            push_valid,
   output ntd_pkg::job_type                push_job,
   input  logic                            push_ready
);
   import ntd_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   job_type job_ff, job_in;
   logic    accept;
   logic    neg;
   logic [VALUE_WIDTH-1:0] raw;

   // The holding register frees up whenever the queue takes its word.
   assign req_stall = hold_valid_ff & ~push_ready;
   assign accept    = req_valid & ~req_stall;

   // Decimal words carry their sign and unsigned magnitude; binary words pass as is.
   always_comb begin
      raw        = VALUE_WIDTH'(req_value);
      neg        = (req_func == FUNC_DECIMAL) & raw[VALUE_WIDTH-1];
      job_in.func = req_func;
      job_in.neg  = neg;
      job_in.mag  = neg ? (VALUE_WIDTH'(0) - raw) : raw;
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign push_valid = hold_valid_ff;
   assign push_job   = job_ff;

endmodule

/* rtl/ntd_queue.sv */
// Short queue of classified words between the front and back ends.
`timescale 1ns / 1ps
module ntd_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ntd_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ntd_pkg::job_type pop_job
);
   import ntd_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   job_type       entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != CW'(0));
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;
   assign pop_job    = entries_ff[rd_ptr_ff];

   // Pointers wrap at the queue depth; the count tracks occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/ntd_back.sv */
// Back end: converts one word to digits and emits the display words serially.
`timescale 1ns / 1ps
module ntd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  ntd_pkg::job_type                   pop_job,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ntd_pkg::CODE_WIDTH-1:0]     rsp_code,
   output logic                               rsp_is_command,
   output logic                               rsp_last
);
   import ntd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SIZE = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   logic [1:0]             state_ff, state_in;
   logic [BCD_WIDTH-1:0]   data_ff, data_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [3:0]             idx_ff, idx_in;
   logic                   pre_ff, pre_in;
   logic                   func_ff, func_in;

   logic                   out_valid_ff, out_valid_in;
   code_type               out_code_ff, out_code_in;
   logic                   out_cmd_ff, out_cmd_in;
   logic                   out_last_ff, out_last_in;

   logic                   out_free;
   logic [BCD_WIDTH-1:0]   adjusted;
   logic [3:0]             top_digit;
   logic [3:0]             cur_digit;
   logic [BYTE_BITS-1:0]   low_byte;
   logic                   cur_bit;

   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign pop_ready = (state_ff == ST_IDLE);

   // Double-dabble correction: every BCD digit of five or more gets three added.
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adjusted[4*i +: 4] = (data_ff[4*i +: 4] >= 4'd5) ?
                              data_ff[4*i +: 4] + 4'd3 : data_ff[4*i +: 4];
      end
   end

   // Position of the most significant nonzero digit; zero leaves position 0.
   always_comb begin
      top_digit = 4'd0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (data_ff[4*i +: 4] != 4'd0) begin
            top_digit = 4'(i);
         end
      end
   end

   assign cur_digit = data_ff[{idx_ff, 2'b00} +: 4];
   assign low_byte  = data_ff[BYTE_BITS-1:0];
   assign cur_bit   = low_byte[idx_ff[2:0]];

   // Sequencer: load, convert and size (decimal words only), then emit one word per free output slot.
   always_comb begin
      state_in     = state_ff;
      data_in      = data_ff;
      bin_in       = bin_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pre_in       = pre_ff;
      func_in      = func_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      out_code_in  = out_code_ff;
      out_cmd_in   = out_cmd_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               func_in = pop_job.func;
               if (pop_job.func == FUNC_BINARY) begin
                  data_in  = BCD_WIDTH'(pop_job.mag[BYTE_BITS-1:0]);
                  pre_in   = 1'b1;
                  idx_in   = 4'(BYTE_BITS - 1);
                  state_in = ST_EMIT;
               end else begin
                  data_in  = '0;
                  bin_in   = pop_job.mag;
                  cnt_in   = '0;
                  pre_in   = pop_job.neg;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            data_in = {adjusted[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in  = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(VALUE_WIDTH - 1)) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            idx_in   = top_digit;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (pre_ff) begin
                  out_code_in = (func_ff == FUNC_BINARY) ? CMD_CLEAR : ASCII_MINUS;
                  out_cmd_in  = (func_ff == FUNC_BINARY);
                  out_last_in = 1'b0;
                  pre_in      = 1'b0;
               end else begin
                  out_code_in = (func_ff == FUNC_BINARY) ?
                                ASCII_ZERO + code_type'(cur_bit) :
                                ASCII_ZERO + code_type'(cur_digit);
                  out_cmd_in  = 1'b0;
                  out_last_in = (idx_ff == 4'd0);
                  if (idx_ff == 4'd0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - 4'd1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      bin_ff      <= bin_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      pre_ff      <= pre_in;
      func_ff     <= func_in;
      out_code_ff <= out_code_in;
      out_cmd_ff  <= out_cmd_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code       = out_code_ff;
   assign rsp_is_command = out_cmd_ff;
   assign rsp_last       = out_last_ff;

endmodule

/* rtl/number_to_display_text_unit.sv */
// Top level of the number-to-display-text unit.
// Each request word becomes a run of display words: in decimal mode an optional
// minus sign and the decimal digits without leading zeros, in binary mode a clear
// command and eight '0'/'1' characters of the low byte; the final word of each run
// has rsp_last set. A request is classified into the front end's holding register
// and then written into the queue; the back end loads a word when idle, and for
// decimal mode runs a shift-and-add-three conversion over all 32 value bits plus a
// sizing step, and finally emits the words one at a time while the output is not
// stalled (up to 11). The back end takes a new word only once it has emitted the
// last word of the previous one, which sets the sustained rate, and the queue lets
// new requests arrive while an earlier one is still being converted or drained.
`timescale 1ns / 1ps
`include "number_to_display_text_unit_defines.svh"
module number_to_display_text_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic signed [ntd_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ntd_pkg::CODE_WIDTH-1:0]         rsp_code,
   output logic                                   rsp_is_command,
   output logic                                   rsp_last
);
   import ntd_pkg::*;

   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop_ready;
   job_type pop_job;

   // Request intake and classification.
   ntd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   // Decoupling queue.
   ntd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Conversion and serial emission.
   ntd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_job        (pop_job),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code       (rsp_code),
      .rsp_is_command (rsp_is_command),
      .rsp_last       (rsp_last)
   );

   // A command word is always the clear command and never ends a run.
   `NTD_ASSERT_IMP(a_cmd_is_clear, clock, reset, rsp_valid && rsp_is_command, (rsp_code == CMD_CLEAR) && !rsp_last)
   // Data words are a minus sign or a decimal digit character.
   `NTD_ASSERT_IMP(a_data_charset, clock, reset, rsp_valid && !rsp_is_command, (rsp_code == ASCII_MINUS) || ((rsp_code >= ASCII_ZERO) && (rsp_code <= ASCII_NINE)))
   // A minus sign is always followed by at least one digit.
   `NTD_ASSERT_IMP(a_minus_not_last, clock, reset, rsp_valid && (rsp_code == ASCII_MINUS), !rsp_last && !rsp_is_command)
   // An accepted request is held by the front end in the following cycle.
   `NTD_ASSERT_NXT(a_front_holds, clock, reset, req_valid && !req_stall, push_valid)

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the number-to-display-text unit.
`timescale 1ns / 1ps
module tb_top;
   import ntd_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 140;
   localparam int TAIL_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [VALUE_WIDTH-1:0] DECIMAL_BASE = 32'd10;

   // One request word waiting to be driven; hold_for_idle makes the sender wait for a drain.
   typedef struct {
      logic                          func;
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          hold_for_idle;
   } request_word_type;

   // One display word the unit is expected to produce.
   typedef struct {
      logic [CODE_WIDTH-1:0] code;
      logic                  is_command;
      logic                  last;
   } display_word_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_func = FUNC_DECIMAL;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [CODE_WIDTH-1:0]         rsp_code;
   logic                          rsp_is_command;
   logic                          rsp_last;

   request_word_type requests_pending[$];
   display_word_type display_words_due[$];

   int failures      = 0;
   int decimal_sent  = 0;
   int binary_sent   = 0;
   int words_checked = 0;
   int idle_waits    = 0;
   int cycle_count   = 0;
   int burst_left    = 1;
   int gap_left      = 0;
   int stall_mode    = 0;
   int stall_left    = 0;
   int stall_tick    = 0;

   number_to_display_text_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code       (rsp_code),
      .rsp_is_command (rsp_is_command),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Works out the display words for one accepted request and queues them.
   task automatic queue_display_words(input logic func, input logic [VALUE_WIDTH-1:0] raw);
      logic [VALUE_WIDTH-1:0] mag;
      logic [3:0]             digits[BCD_DIGITS];
      int                     count;
      count = 0;
      if (func == FUNC_BINARY) begin
         display_words_due.push_back('{CMD_CLEAR, 1'b1, 1'b0});
         for (int b = BYTE_BITS - 1; b >= 0; b--) begin
            display_words_due.push_back('{ASCII_ZERO + {7'd0, raw[b]}, 1'b0, b == 0});
         end
      end else begin
         // Two's complement negation also covers the most negative value.
         mag = raw[VALUE_WIDTH-1] ? 32'd0 - raw : raw;
         if (mag == '0) begin
            display_words_due.push_back('{ASCII_ZERO, 1'b0, 1'b1});
         end else begin
            while (mag != '0) begin
               digits[count] = 4'(mag % DECIMAL_BASE);
               mag = mag / DECIMAL_BASE;
               count++;
            end
            if (raw[VALUE_WIDTH-1]) begin
               display_words_due.push_back('{ASCII_MINUS, 1'b0, 1'b0});
            end
            for (int i = count - 1; i >= 0; i--) begin
               display_words_due.push_back('{ASCII_ZERO + {4'd0, digits[i]}, 1'b0, i == 0});
            end
         end
      end
   endtask

   task automatic note_failure(input string what, input display_word_type due);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("ERROR %s at cycle %0d: expected code %h cmd %b last %b,",
                  what, cycle_count, due.code, due.is_command, due.last);
         $display("      got code %h cmd %b last %b",
                  rsp_code, rsp_is_command, rsp_last);
      end
   endtask

   // Picks a value that tends toward digit-count boundaries and the extremes.
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      logic [VALUE_WIDTH-1:0] result;
      logic [VALUE_WIDTH-1:0] power;
      power = 32'd1;
      case ($urandom_range(0, 5))
         0, 1: result = $urandom;
         2: result = $urandom_range(0, 999);
         3: result = 32'd0 - $urandom_range(1, 999);
         4: begin
            repeat ($urandom_range(0, 9)) power = power * DECIMAL_BASE;
            result = power - $urandom_range(0, 1);
            if ($urandom_range(0, 1) == 1) result = 32'd0 - result;
         end
         default: begin
            result = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                 : 32'h8000_0000 + $urandom_range(0, 3);
         end
      endcase
      return result;
   endfunction

   // Stimulus: directed corner cases first, then random words with a few forced drains.
   initial begin
      requests_pending.push_back('{FUNC_DECIMAL, 32'sd0, 1'b0});
      requests_pending.push_back('{FUNC_DECIMAL, 32'sd1, 1'b0});
      requests_pending.push_back('{FUNC_DECIMAL, -32'sd1, 1'b0});
      requests_pending.push_back('{FUNC_DECIMAL, 32'sd9, 1'b0});
      requests_pending.push_back('{FUNC_DECIMAL, 32'sd10, 1'b0});
      requests_pending.push_back('{FUNC_DECIMAL, -32'sd10, 1'b0});
      requests_pending.push_back('{FUNC_DECIMAL, 32'sh7FFF_FFFF, 1'b0});
      requests_pending.push_back('{FUNC_DECIMAL, 32'sh8000_0000, 1'b0});
      requests_pending.push_back('{FUNC_DECIMAL, 32'sd1000000000, 1'b0});
      requests_pending.push_back('{FUNC_DECIMAL, -32'sd999999999, 1'b0});
      requests_pending.push_back('{FUNC_DECIMAL, 32'sd123456789, 1'b0});
      requests_pending.push_back('{FUNC_BINARY, 32'sd0, 1'b0});
      requests_pending.push_back('{FUNC_BINARY, 32'sd255, 1'b0});
      requests_pending.push_back('{FUNC_BINARY, 32'sh0000_00AA, 1'b0});
      requests_pending.push_back('{FUNC_BINARY, 32'sh0000_0055, 1'b0});
      requests_pending.push_back('{FUNC_BINARY, 32'sh0000_0080, 1'b0});
      requests_pending.push_back('{FUNC_BINARY, 32'sh0000_0001, 1'b0});
      requests_pending.push_back('{FUNC_BINARY, 32'shFFFF_FF00, 1'b0});
      requests_pending.push_back('{FUNC_BINARY, 32'sh1234_5678, 1'b0});
      requests_pending.push_back('{FUNC_BINARY, -32'sd1, 1'b0});
      requests_pending.push_back('{FUNC_DECIMAL, 32'sh8000_0000, 1'b0});
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         requests_pending.push_back('{($urandom_range(0, 2) == 0) ? FUNC_BINARY : FUNC_DECIMAL,
                                      pick_value(), n % 40 == 0});
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (requests_pending.size() != 0 || req_valid || display_words_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      failures += display_words_due.size();

      $display("Summary: %0d decimal and %0d binary requests, %0d display words checked,",
               decimal_sent, binary_sent, words_checked);
      $display("         %0d full drains, %0d failures.", idle_waits, failures);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 8);
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            queue_display_words(req_func, req_value);
            if (req_func == FUNC_BINARY) binary_sent++;
            else decimal_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (requests_pending.size() != 0 &&
                         (!requests_pending[0].hold_for_idle ||
                          display_words_due.size() == 0)) begin
               if (requests_pending[0].hold_for_idle) idle_waits++;
               req_valid <= 1'b1;
               req_func  <= requests_pending[0].func;
               req_value <= requests_pending[0].value;
               void'(requests_pending.pop_front());
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  case ($urandom_range(0, 7))
                     0, 1, 2: gap_left = 0;
                     7:       gap_left = $urandom_range(40, 90);
                     default: gap_left = $urandom_range(1, 30);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each accepted word and stalls on a pattern that changes mode.
   always @(posedge clock) begin
      display_word_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (display_words_due.size() == 0) begin
               due = '{'0, 1'b0, 1'b0};
               note_failure("unexpected word", due);
            end else begin
               due = display_words_due.pop_front();
               if (rsp_code !== due.code || rsp_is_command !== due.is_command ||
                   rsp_last !== due.last) begin
                  note_failure("word mismatch", due);
               end
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(30, 250);
         end
         stall_left--;
         stall_tick++;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (stall_tick % 8) >= 5;
         endcase
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words still due.",
                  cycle_count, display_words_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
